>>> hdl/wbps_pkg.sv
package wbps_pkg;

    // Fixed register geometry
    localparam int PAT_REG_BYTES = 32;
    localparam int PAT_IDX_W     = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int POS_W         = 32;
    localparam int ADDR_W        = 64;
    localparam int LEN_FIELD_W   = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MID_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MID_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE     = 3'd6;

    typedef struct packed {
        logic [8*PAT_REG_BYTES-1:0] pattern_bits;
        logic [PAT_REG_BYTES-1:0]   care_mask;
        logic [LEN_FIELD_W-1:0]     pattern_length;
        logic [ADDR_W-1:0]          image_base;
    } wbps_cfg_t;

endpackage

>>> hdl/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scanner. Image bytes arrive one request per clock on the in_ channel
// unless stalled, last_byte marking the final byte of each image; each image yields exactly
// one result on the out_ channel: found set with the offset and absolute address of the first
// match, or found clear with zero offset and address when the image ends without one. Pattern
// bytes, care mask, pattern length (1..PATTERN_MAX) and image base are loaded through the
// write port; the user must load them only while no image byte is in flight, unenforced by the
// block. Throughput is one byte per clock unless stalled: a row of PATTERN_MAX-1 cells holds
// the recent bytes and all of them are compared against the right-aligned pattern in the same
// cycle the new byte arrives. An output register plus a skid register decouple the two sides;
// in_stall rises only when both hold undelivered results. The byte position saturates at 2^32-1.
module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [POS_W-1:0]      match_offset,
    output logic [ADDR_W-1:0]     match_address
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  offset;
        logic [ADDR_W-1:0] address;
    } wbps_result_t;

    wbps_cfg_t cfg;

    logic [7:0]           pat_arr [PAT_REG_BYTES];
    logic [7:0]           want_al [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] care_al;
    logic [PATTERN_MAX-1:0] hit;
    logic [7:0]           tap [PATTERN_MAX];
    logic [LEN_W-1:0]     act_len;

    logic                 accept;
    logic                 pos_ok;
    logic                 match;
    logic                 produce;
    wbps_result_t         new_res;
    logic [POS_W-1:0]     new_off;

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic                 done_reg;
    logic                 done_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    wbps_result_t         out_res_reg;
    wbps_result_t         out_res_next;
    wbps_result_t         skid_res_reg;
    wbps_result_t         skid_res_next;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Effective pattern length: zero acts as one, clamp to PATTERN_MAX
    always_comb
    begin
        if (cfg.pattern_length == '0)
            act_len = LEN_W'(1);
        else if (int'(cfg.pattern_length) > PATTERN_MAX)
            act_len = LEN_W'(PATTERN_MAX);
        else
            act_len = LEN_W'(cfg.pattern_length);
    end

    always_comb
    begin
        for (int i = 0; i < PAT_REG_BYTES; i++)
            pat_arr[i] = cfg.pattern_bits[8*i +: 8];
    end

    // Right-align the pattern: tap b (age b) meets pattern byte len-1-b.
    // Taps past the length and pattern bytes without a register are wildcards.
    always_comb
    begin
        int                   j_full;
        logic [PAT_IDX_W-1:0] j_idx;
        for (int b = 0; b < PATTERN_MAX; b++)
        begin
            j_full     = int'(act_len) - 1 - b;
            j_idx      = PAT_IDX_W'(j_full);
            want_al[b] = '0;
            care_al[b] = 1'b0;
            if (j_full >= 0 && j_full < PAT_REG_BYTES)
            begin
                want_al[b] = pat_arr[j_idx];
                care_al[b] = cfg.care_mask[j_idx];
            end
        end
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;

    // Tap 0 is the incoming byte itself; taps 1.. live in the cell row
    assign tap[0] = data_byte;
    assign hit[0] = !care_al[0] || (data_byte == want_al[0]);

    for (genvar c = 1; c < PATTERN_MAX; c++)
    begin : g_cell
        wbps_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept && !last_byte),
            .clear    (accept && last_byte),
            .byte_in  (tap[c-1]),
            .want     (want_al[c]),
            .care     (care_al[c]),
            .byte_out (tap[c]),
            .hit      (hit[c])
        );
    end

    // Match needs a full window of this image's bytes behind the current one
    assign pos_ok  = pos_reg >= (POS_W'(act_len) - POS_W'(1));
    assign match   = !done_reg && pos_ok && (&hit);
    assign new_off = pos_reg - (POS_W'(act_len) - POS_W'(1));

    always_comb
    begin
        new_res = '0;
        if (match)
        begin
            new_res.found   = 1'b1;
            new_res.offset  = new_off;
            new_res.address = cfg.image_base + ADDR_W'(new_off);
        end
    end

    assign produce = accept && (match || (!done_reg && last_byte));

    // Advance position and done flag; the last byte rearms both
    always_comb
    begin
        pos_next  = pos_reg;
        done_next = done_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next  = '0;
                done_next = 1'b0;
            end
            else
            begin
                if (pos_reg != '1)
                    pos_next = pos_reg + POS_W'(1);
                if (match)
                    done_next = 1'b1;
            end
        end
    end

    // Output register with skid: a new result parks in the skid stage
    // only while the output register holds an untaken one
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = produce;
                out_res_next   = new_res;
            end
        end
        else if (produce)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = out_res_reg.found;
    assign match_offset  = out_res_reg.offset;
    assign match_address = out_res_reg.address;

    // The skid stage fills only behind a held output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // A miss result carries zero offset and address
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_offset == '0 && match_address == '0))
        else $error("miss result with nonzero offset or address");

    // The last byte of an image rearms the scan
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (pos_reg == '0 && !done_reg))
        else $error("scan not rearmed after the last byte");

    // Once a match is reported, no further result until the image ends
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && accept && !last_byte) |-> !produce)
        else $error("second result within one image");

endmodule

>>> hdl/wbps_cfg.sv
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output wbps_cfg_t             cfg
);

    wbps_cfg_t cfg_reg;
    wbps_cfg_t cfg_next;

    // Decode the write onto one register; unknown indexes drop the request
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LO:     cfg_next.pattern_bits[0   +: 64] = cfg_data;
                REG_PATTERN_MID_LO: cfg_next.pattern_bits[64  +: 64] = cfg_data;
                REG_PATTERN_MID_HI: cfg_next.pattern_bits[128 +: 64] = cfg_data;
                REG_PATTERN_HI:     cfg_next.pattern_bits[192 +: 64] = cfg_data;
                REG_CARE_MASK:      cfg_next.care_mask = cfg_data[PAT_REG_BYTES-1:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg_data[LEN_FIELD_W-1:0];
                REG_IMAGE_BASE:     cfg_next.image_base = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pattern_bits:   '0,
                         care_mask:      '0,
                         pattern_length: LEN_FIELD_W'(1),
                         image_base:     '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/wbps_cell.sv
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] byte_in,
    input  logic [7:0] want,
    input  logic       care,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Clear wins over shift: the last byte of an image empties the row
    always_comb
    begin
        byte_next = byte_reg;
        if (clear)
            byte_next = '0;
        else if (shift_en)
            byte_next = byte_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= '0;
        else
            byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;
    assign hit      = !care || (byte_reg == want);

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import wbps_pkg::*;
;

    localparam int SETTLE_CYCLES  = 4;     // result register plus skid register, with margin
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake and no register write
    localparam int DIRECTED_ITEMS = 25;
    localparam int PHASE_ITEMS    = 140;

    // One scan outcome as it leaves the block
    typedef struct {
        logic              found;
        logic [POS_W-1:0]  offset;
        logic [ADDR_W-1:0] address;
    } scan_result_t;

    // Scoreboard: mirrors the scanner state, predicts one outcome per image and matches
    // the outcomes coming out of the block against that prediction in order.
    class scan_scoreboard;
        logic [8*PAT_REG_BYTES-1:0] pattern_bits;
        logic [PAT_REG_BYTES-1:0]   care;
        logic [LEN_FIELD_W-1:0]     length_field;
        logic [ADDR_W-1:0]          base;
        logic [7:0]                 history [PAT_REG_BYTES-1];
        logic [POS_W-1:0]           position;
        logic                       matched;
        scan_result_t               expected_scans[$];
        int                         errors;

        function new();
            pattern_bits = '0;
            care         = '0;
            length_field = LEN_FIELD_W'(1);
            base         = '0;
            errors       = 0;
            rearm();
        endfunction

        function void rearm();
            foreach (history[k])
                history[k] = 8'h00;
            position = '0;
            matched  = 1'b0;
        endfunction

        // Length zero scans as one byte, anything above the register file as the full width
        function int active_span();
            if (length_field == 0)
                return 1;
            if (length_field > PAT_REG_BYTES)
                return PAT_REG_BYTES;
            return int'(length_field);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PATTERN_LO:     pattern_bits[63:0]    = value;
                REG_PATTERN_MID_LO: pattern_bits[127:64]  = value;
                REG_PATTERN_MID_HI: pattern_bits[191:128] = value;
                REG_PATTERN_HI:     pattern_bits[255:192] = value;
                REG_CARE_MASK:      care                  = value[PAT_REG_BYTES-1:0];
                REG_PATTERN_LENGTH: length_field          = value[LEN_FIELD_W-1:0];
                REG_IMAGE_BASE:     base                  = value;
                default:            ;
            endcase
        endfunction

        function void note_byte(logic [7:0] value, logic closes_image);
            int           span;
            int           back;
            logic [7:0]   seen;
            logic         hit;
            scan_result_t outcome;
            span = active_span();
            hit  = 1'b0;
            if (!matched && position >= POS_W'(span - 1))
            begin
                hit = 1'b1;
                // Right-aligned compare: pattern byte span-1 lines up with the new byte
                for (int j = 0; j < span; j++)
                begin
                    back = span - 1 - j;
                    seen = (back == 0) ? value : history[back - 1];
                    if (care[j] && seen != pattern_bits[8*j +: 8])
                        hit = 1'b0;
                end
            end
            if (hit)
            begin
                outcome.found   = 1'b1;
                outcome.offset  = position - POS_W'(span - 1);
                outcome.address = base + ADDR_W'(outcome.offset);
                expected_scans = {expected_scans, outcome};
                matched = 1'b1;
            end
            else if (!matched && closes_image)
            begin
                outcome.found   = 1'b0;
                outcome.offset  = '0;
                outcome.address = '0;
                expected_scans = {expected_scans, outcome};
            end
            if (closes_image)
                rearm();
            else
            begin
                for (int k = PAT_REG_BYTES - 2; k > 0; k--)
                    history[k] = history[k - 1];
                history[0] = value;
                if (position != '1)
                    position++;
            end
        endfunction

        function void check_scan(logic f, logic [POS_W-1:0] off, logic [ADDR_W-1:0] addr);
            scan_result_t want;
            if (expected_scans.size() == 0)
            begin
                $display("%0t: unexpected result: found %0d offset %0d address %h",
                         $time, f, off, addr);
                errors++;
                return;
            end
            want = expected_scans.pop_front();
            if (f !== want.found)
            begin
                $display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found, f);
                errors++;
            end
            if (off !== want.offset)
            begin
                $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                         $time, want.offset, off);
                errors++;
            end
            if (addr !== want.address)
            begin
                $display("%0t: match_address mismatch: expected %h, actual %h",
                         $time, want.address, addr);
                errors++;
            end
        endfunction

        function int pending();
            return expected_scans.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            data_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [POS_W-1:0]      match_offset;
    logic [ADDR_W-1:0]     match_address;

    scan_scoreboard sb;
    int             send_idle_pct;
    int             stall_pct;
    int             items_sent;
    int             idle_cycles;

    wildcard_byte_pattern_scan u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_offset  (match_offset),
        .match_address (match_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stall at random at the configured rate. Stall is free to change at any
    // edge; the block must hold its result until it is taken.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    // Result monitor: values read here are the pre-edge ones, i.e. what the edge samples
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_scan(found, match_offset, match_address);
    end

    // Watchdog: any handshake or register write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive one image byte as a request; insert a random gap first, with valid low.
    // Valid stays high from one request to the next when no gap is drawn.
    task automatic send_request(input logic [7:0] value, input logic closes_image);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= closes_image;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(value, closes_image);
        items_sent++;
    endtask

    task automatic run_image(input logic [7:0] img[$]);
        foreach (img[i])
            send_request(img[i], i == img.size() - 1);
    endtask

    // Drop valid, drain every outstanding result, then let the pipeline settle so a
    // register write can never land on a byte still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hold write enable across back-to-back writes; the caller lowers it afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    // Write all registers; junk goes into the unused upper bits of the narrow ones
    task automatic load_config(input logic [8*PAT_REG_BYTES-1:0] pat,
                               input logic [PAT_REG_BYTES-1:0]   care_bits,
                               input logic [LEN_FIELD_W-1:0]     len,
                               input logic [ADDR_W-1:0]          base_addr);
        write_reg(REG_PATTERN_LO,     pat[63:0]);
        write_reg(REG_PATTERN_MID_LO, pat[127:64]);
        write_reg(REG_PATTERN_MID_HI, pat[191:128]);
        write_reg(REG_PATTERN_HI,     pat[255:192]);
        write_reg(REG_CARE_MASK,      {32'($urandom), care_bits});
        write_reg(REG_PATTERN_LENGTH, {32'($urandom), 26'($urandom), len});
        write_reg(REG_IMAGE_BASE,     base_addr);
        cfg_write <= 1'b0;
    endtask

    // Pick a random setting, favoring short patterns but reaching every extreme
    task automatic random_setup();
        logic [8*PAT_REG_BYTES-1:0] pat;
        logic [PAT_REG_BYTES-1:0]   care_bits;
        logic [LEN_FIELD_W-1:0]     len;
        logic [ADDR_W-1:0]          base_addr;
        int                         pick;
        for (int w = 0; w < 4; w++)
        begin
            case ($urandom_range(9, 0))
                0:       pat[64*w +: 64] = '0;
                1:       pat[64*w +: 64] = '1;
                default: pat[64*w +: 64] = {$urandom, $urandom};
            endcase
        end
        case ($urandom_range(7, 0))
            0:       care_bits = '0;
            1, 2:    care_bits = '1;
            default: care_bits = $urandom;
        endcase
        pick = $urandom_range(99, 0);
        if (pick < 50)
            len = LEN_FIELD_W'($urandom_range(4, 1));
        else if (pick < 75)
            len = LEN_FIELD_W'($urandom_range(12, 5));
        else if (pick < 85)
            len = LEN_FIELD_W'($urandom_range(31, 13));
        else if (pick < 92)
            len = LEN_FIELD_W'(PAT_REG_BYTES);
        else if (pick < 95)
            len = '0;
        else
            len = LEN_FIELD_W'($urandom_range(63, 33));
        case ($urandom_range(5, 0))
            0:       base_addr = '0;
            1:       base_addr = '1;
            default: base_addr = {$urandom, $urandom};
        endcase
        load_config(pat, care_bits, len, base_addr);
    endtask

    // Build one image. Most images carry the pattern at a random spot with random bytes
    // in the wildcard slots; some of those get one bit flipped to make a near miss. The
    // filler is sometimes drawn from the pattern bytes to provoke partial and early hits.
    task automatic build_image(output logic [7:0] img[$]);
        int   span;
        int   size;
        int   start;
        int   slot;
        logic lookalike;
        span = sb.active_span();
        if ($urandom_range(99, 0) < 85)
            size = $urandom_range(span + 6, 1);
        else
            size = $urandom_range(span + 40, span);
        lookalike = 1'($urandom_range(1, 0));
        img = {};
        for (int j = 0; j < size; j++)
        begin
            slot = $urandom_range(span - 1, 0);
            if (lookalike && $urandom_range(1, 0))
                img = {img, sb.pattern_bits[8*slot +: 8]};
            else
                img = {img, 8'($urandom)};
        end
        if (size >= span && $urandom_range(99, 0) < 70)
        begin
            start = $urandom_range(size - span, 0);
            for (int j = 0; j < span; j++)
            begin
                if (sb.care[j])
                    img[start + j] = sb.pattern_bits[8*j +: 8];
            end
            if ($urandom_range(99, 0) < 20)
            begin
                slot = $urandom_range(span - 1, 0);
                img[start + slot] = img[start + slot] ^ 8'(1 << $urandom_range(7, 0));
            end
        end
    endtask

    initial
    begin
        logic [7:0] img[$];
        sb            = new();
        send_idle_pct = 10;
        stall_pct     = 84;
        items_sent    = 0;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        data_byte     <= 8'h00;
        last_byte     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: one-byte pattern, all wildcard, so the first byte always hits.
        // A single-byte image matches on its own last byte; the longer one checks that
        // bytes after a hit are dropped and the closing byte yields nothing.
        run_image('{8'h00});
        run_image('{8'hFF, 8'h12, 8'h34});

        // DE AD ?? EF with a base that wraps the address
        wait_idle();
        load_config(256'h0000_0000_EFBE_ADDE, 32'h0000_000B, 6'd4, '1);
        run_image('{8'hDE, 8'hAD});                            // shorter than the pattern
        run_image('{8'h11, 8'hDE, 8'hAD, 8'h00, 8'hEF});       // hit on the closing byte
        run_image('{8'hDE, 8'hAD, 8'h77, 8'hEF, 8'h55, 8'h66}); // hit, then ignored tail
        run_image('{8'hDE, 8'hAD, 8'hBE, 8'hEE});              // miss by one byte

        // Length zero scans as a single byte
        wait_idle();
        load_config('0, 32'h0000_0001, 6'd0, 64'h8000_0000_0000_0000);
        run_image('{8'h01, 8'h00});

        // Oversized length clamps to the full width; a short image cannot fit it
        wait_idle();
        load_config('1, '1, 6'd63, 64'h0000_0000_0000_1000);
        run_image('{8'hFF, 8'hFF});

        // Random part in three idling phases: slow receiver, slow sender, then full rate
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 10;
                    stall_pct     = 84;
                end
                1:
                begin
                    send_idle_pct = 84;
                    stall_pct     = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            while (items_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS)
            begin
                wait_idle();
                random_setup();
                repeat (3)
                begin
                    build_image(img);
                    run_image(img);
                end
            end
        end

        // Drain, let the pipeline settle, then report
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
        begin
            if (sb.pending() != 0)
                $display("%0t: %0d expected results never arrived", $time, sb.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/wbps_pkg.sv
hdl/wbps_cfg.sv
hdl/wbps_cell.sv
hdl/wildcard_byte_pattern_scan.sv
dv/testbench.sv
